/* hdl/pcsp_pkg.sv */
package pcsp_pkg;

    // limits of the number fields
    localparam logic [11:0] MAX_WIDTH     = 12'd256;
    localparam logic [11:0] MAX_PRECISION = 12'd192;

    // modifier kinds
    localparam logic [1:0] MOD_NONE = 2'd0;
    localparam logic [1:0] MOD_L    = 2'd1;
    localparam logic [1:0] MOD_H    = 2'd2;
    localparam logic [1:0] MOD_BIGL = 2'd3;

    // number field targets
    localparam logic [1:0] TGT_WIDTH  = 2'd0;
    localparam logic [1:0] TGT_PREC   = 2'd1;
    localparam logic [1:0] TGT_CLOSED = 2'd2;

    // slot types
    localparam logic [3:0] SLOT_UNSUPPORTED = 4'd0;
    localparam logic [3:0] SLOT_PERCENT     = 4'd1;
    localparam logic [3:0] SLOT_INT         = 4'd2;
    localparam logic [3:0] SLOT_UINT        = 4'd3;
    localparam logic [3:0] SLOT_FLOAT       = 4'd4;
    localparam logic [3:0] SLOT_STRING      = 4'd5;
    localparam logic [3:0] SLOT_CHAR        = 4'd6;
    localparam logic [3:0] SLOT_SHORT       = 4'd7;
    localparam logic [3:0] SLOT_LONG64      = 4'd8;
    localparam logic [3:0] SLOT_LONG        = 4'd9;
    localparam logic [3:0] SLOT_UCHAR       = 4'd10;
    localparam logic [3:0] SLOT_USHORT      = 4'd11;
    localparam logic [3:0] SLOT_ULONG       = 4'd12;
    localparam logic [3:0] SLOT_ULONG64     = 4'd13;
    localparam logic [3:0] SLOT_LONGDOUBLE  = 4'd14;

    // error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_EXTRA_NUMBER  = 4'd1;
    localparam logic [3:0] ERR_PREC_LARGE    = 4'd2;
    localparam logic [3:0] ERR_WIDTH_LARGE   = 4'd3;
    localparam logic [3:0] ERR_MOD_UNSUPP    = 4'd4;
    localparam logic [3:0] ERR_TYPE_UNSUPP   = 4'd5;
    localparam logic [3:0] ERR_TOO_MANY_MODS = 4'd6;
    localparam logic [3:0] ERR_DOTS          = 4'd7;
    localparam logic [3:0] ERR_DOLLAR        = 4'd8;
    localparam logic [3:0] ERR_STAR_WIDTH    = 4'd9;
    localparam logic [3:0] ERR_STAR_PREC     = 4'd10;
    localparam logic [3:0] ERR_FLAG_ORDER    = 4'd11;
    localparam logic [3:0] ERR_BAD_CHAR      = 4'd12;
    localparam logic [3:0] ERR_NO_TYPE       = 4'd13;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UL     = 8'h4C;
    localparam logic [7:0] CH_US     = 8'h53;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LC     = 8'h63;
    localparam logic [7:0] CH_LD     = 8'h64;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LG     = 8'h67;
    localparam logic [7:0] CH_LH     = 8'h68;
    localparam logic [7:0] CH_LI     = 8'h69;
    localparam logic [7:0] CH_LJ     = 8'h6A;
    localparam logic [7:0] CH_LL     = 8'h6C;
    localparam logic [7:0] CH_LM     = 8'h6D;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LO     = 8'h6F;
    localparam logic [7:0] CH_LQ     = 8'h71;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    // running parser state
    typedef struct packed {
        logic       in_spec;
        logic [1:0] modifier_kind;
        logic [1:0] h_count;
        logic [1:0] l_count;
        logic [1:0] big_l_count;
        logic [8:0] width_acc;
        logic [7:0] precision_acc;
        logic [1:0] number_target;
        logic       dot_seen;
    } t_state;

    // one result item
    typedef struct packed {
        logic [3:0] slot_type;
        logic [3:0] error_code;
        logic [8:0] field_width;
        logic [7:0] field_precision;
        logic [7:0] bad_char;
    } t_result;

    localparam t_state STATE_CLEAR = '{
        in_spec:       1'b0,
        modifier_kind: MOD_NONE,
        h_count:       2'd0,
        l_count:       2'd0,
        big_l_count:   2'd0,
        width_acc:     9'd0,
        precision_acc: 8'd0,
        number_target: TGT_WIDTH,
        dot_seen:      1'b0
    };

endpackage

/* hdl/pcsp_step.sv */
module pcsp_step
    import pcsp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_ch,
    output t_state     o_state,
    output logic       o_emit,
    output t_result    o_result
);

    t_state      s;
    logic        fin;
    logic [3:0]  f_type;
    logic [3:0]  f_err;
    logic [3:0]  digit;
    logic [11:0] w_next;
    logic [11:0] p_next;
    logic        sgn;

    // candidate values of the number fields for a digit
    assign digit  = i_ch[3:0];
    assign w_next = {i_state.width_acc, 3'b000} + {2'b00, i_state.width_acc, 1'b0}
                  + {8'd0, digit};
    assign p_next = {1'b0, i_state.precision_acc, 3'b000}
                  + {3'b000, i_state.precision_acc, 1'b0} + {8'd0, digit};
    assign sgn    = (i_ch == CH_LD) || (i_ch == CH_LI);

    // one character of parsing
    always_comb begin
        s      = i_state;
        fin    = 1'b0;
        f_type = SLOT_UNSUPPORTED;
        f_err  = ERR_NONE;
        if (!i_state.in_spec) begin
            if (i_ch == CH_PCT) begin
                s         = STATE_CLEAR;
                s.in_spec = 1'b1;
            end
        end else if (i_ch == CH_NUL) begin
            fin   = 1'b1;
            f_err = ERR_NO_TYPE;
        end else if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            if (i_state.number_target == TGT_CLOSED) begin
                fin   = 1'b1;
                f_err = ERR_EXTRA_NUMBER;
            end else if (i_state.number_target == TGT_PREC) begin
                if (p_next > MAX_PRECISION) begin
                    s.precision_acc = MAX_PRECISION[7:0];
                    fin             = 1'b1;
                    f_err           = ERR_PREC_LARGE;
                end else begin
                    s.precision_acc = p_next[7:0];
                end
            end else begin
                if (w_next > MAX_WIDTH) begin
                    s.width_acc = MAX_WIDTH[8:0];
                    fin         = 1'b1;
                    f_err       = ERR_WIDTH_LARGE;
                end else begin
                    s.width_acc = w_next[8:0];
                end
            end
        end else begin
            // a non-digit closes a nonzero active field
            if (i_state.number_target == TGT_PREC && i_state.precision_acc != 8'd0) begin
                s.number_target = TGT_CLOSED;
            end else if (i_state.number_target == TGT_WIDTH
                         && i_state.width_acc != 9'd0) begin
                s.number_target = TGT_CLOSED;
            end
            unique case (i_ch)
                CH_LD, CH_LI, CH_LO, CH_LU, CH_LX, CH_UX: begin
                    fin = 1'b1;
                    if (i_state.h_count == 2'd0 && i_state.l_count == 2'd0) begin
                        f_type = sgn ? SLOT_INT : SLOT_UINT;
                    end else if (i_state.h_count == 2'd1) begin
                        f_type = sgn ? SLOT_SHORT : SLOT_USHORT;
                    end else if (i_state.h_count == 2'd2) begin
                        f_type = sgn ? SLOT_CHAR : SLOT_UCHAR;
                    end else if (i_state.l_count == 2'd1) begin
                        f_type = sgn ? SLOT_LONG : SLOT_ULONG;
                    end else if (i_state.l_count == 2'd2) begin
                        f_type = sgn ? SLOT_LONG64 : SLOT_ULONG64;
                    end else begin
                        f_err = (i_state.modifier_kind != MOD_NONE) ? ERR_MOD_UNSUPP
                                                                    : ERR_NONE;
                    end
                end
                CH_LE, CH_UE, CH_LF, CH_UF, CH_LG, CH_UG, CH_LA, CH_UA: begin
                    fin    = 1'b1;
                    f_type = (i_state.big_l_count == 2'd0) ? SLOT_FLOAT : SLOT_LONGDOUBLE;
                end
                CH_LC, CH_LS: begin
                    fin = 1'b1;
                    if (i_state.modifier_kind != MOD_NONE) begin
                        f_err = ERR_MOD_UNSUPP;
                    end else begin
                        f_type = (i_ch == CH_LC) ? SLOT_UCHAR : SLOT_STRING;
                    end
                end
                CH_PCT: begin
                    fin    = 1'b1;
                    f_type = SLOT_PERCENT;
                end
                CH_BSLASH: begin
                    fin = 1'b0;
                end
                CH_UC, CH_US, CH_LN, CH_LM: begin
                    fin   = 1'b1;
                    f_err = ERR_TYPE_UNSUPP;
                end
                CH_LL: begin
                    if (i_state.modifier_kind == MOD_NONE) begin
                        s.modifier_kind = MOD_L;
                        s.l_count       = i_state.l_count + 2'd1;
                    end else if (i_state.modifier_kind != MOD_L || i_state.l_count >= 2'd2) begin
                        fin   = 1'b1;
                        f_err = ERR_TOO_MANY_MODS;
                    end else begin
                        s.l_count = i_state.l_count + 2'd1;
                    end
                end
                CH_LH: begin
                    if (i_state.modifier_kind == MOD_NONE) begin
                        s.modifier_kind = MOD_H;
                        s.h_count       = i_state.h_count + 2'd1;
                    end else if (i_state.modifier_kind != MOD_H || i_state.h_count >= 2'd2) begin
                        fin   = 1'b1;
                        f_err = ERR_TOO_MANY_MODS;
                    end else begin
                        s.h_count = i_state.h_count + 2'd1;
                    end
                end
                CH_UL: begin
                    s.big_l_count = i_state.big_l_count + 2'd1;
                    if (i_state.modifier_kind != MOD_NONE) begin
                        fin   = 1'b1;
                        f_err = ERR_TOO_MANY_MODS;
                    end else begin
                        s.modifier_kind = MOD_BIGL;
                    end
                end
                CH_LJ, CH_LQ, CH_LT, CH_LZ, CH_UZ: begin
                    fin   = 1'b1;
                    f_err = ERR_MOD_UNSUPP;
                end
                CH_DOT: begin
                    if (i_state.dot_seen) begin
                        fin   = 1'b1;
                        f_err = ERR_DOTS;
                    end else begin
                        s.number_target = TGT_PREC;
                        s.dot_seen      = 1'b1;
                    end
                end
                CH_DOLLAR: begin
                    fin   = 1'b1;
                    f_err = ERR_DOLLAR;
                end
                CH_STAR: begin
                    fin   = 1'b1;
                    f_err = i_state.dot_seen ? ERR_STAR_PREC : ERR_STAR_WIDTH;
                end
                CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH: begin
                    if (i_state.dot_seen) begin
                        fin   = 1'b1;
                        f_err = ERR_FLAG_ORDER;
                    end
                end
                default: begin
                    fin   = 1'b1;
                    f_err = ERR_BAD_CHAR;
                end
            endcase
        end

        // result fields come from the fields as updated by this character
        o_result.slot_type       = f_type;
        o_result.error_code      = f_err;
        o_result.field_width     = s.width_acc;
        o_result.field_precision = s.precision_acc;
        o_result.bad_char        = i_ch;
        o_emit                   = fin;
        o_state                  = fin ? STATE_CLEAR : s;
    end

endmodule

/* hdl/printf_conversion_spec_parser.sv */
// Parses printf conversion specifiers from a stream of format-string bytes, one byte per
// item. Bytes outside a specifier produce nothing; '%' opens a specifier, and the byte that
// ends it (a conversion character, an error, or NUL) produces one result item with the slot
// type, error code, width, precision and the ending byte. Throughput is one byte per clock
// while the output is not stalled: a byte is captured in an input register, parsed
// combinationally against the running state, and its result lands in an output register.
// The output register stalls the parse stage only when it holds a result that has not
// been taken; no reset sequence is needed beyond the synchronous reset.
module printf_conversion_spec_parser
    import pcsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_slot_type,
    output logic [3:0] o_error_code,
    output logic [8:0] o_field_width,
    output logic [7:0] o_field_precision,
    output logic [7:0] o_bad_char
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_result;
    t_result    n_result;
    logic       n_emit;
    logic       fire;

    // parse stage runs whenever a byte is held and the output register can take a result
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    pcsp_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .o_state  (n_state),
        .o_emit   (n_emit),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ch <= i_ch;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= n_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_slot_type       = r_result.slot_type;
    assign o_error_code      = r_result.error_code;
    assign o_field_width     = r_result.field_width;
    assign o_field_precision = r_result.field_precision;
    assign o_bad_char        = r_result.bad_char;

endmodule

/* tb/printf_conversion_spec_parser_checker.sv */
module printf_conversion_spec_parser_checker
    import pcsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_ch_valid,
    input  logic       i_ch_ready,
    input  logic [7:0] i_ch,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [3:0] i_slot_type,
    input  logic [3:0] i_error_code,
    input  logic [8:0] i_field_width,
    input  logic [7:0] i_field_precision,
    input  logic [7:0] i_bad_char,
    output int         o_mismatches,
    output int         o_specs_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_state  spec_st = STATE_CLEAR;
    t_result spec_results_q[$];
    int      mismatch_total = 0;

    // advance the parser state by one byte, return the result it ends with
    task automatic parse_format_byte(input logic [7:0] b, output bit emits,
                                     output t_result res);
        int unsigned acc;
        logic [3:0]  slot;
        logic [3:0]  err;
        bit          ends;
        bit          sgn;
        emits = 1'b0;
        res   = '0;
        slot  = SLOT_UNSUPPORTED;
        err   = ERR_NONE;
        ends  = 1'b1;
        if (!spec_st.in_spec) begin
            // outside a specifier only a percent sign matters
            if (b == CH_PCT) begin
                spec_st         = STATE_CLEAR;
                spec_st.in_spec = 1'b1;
            end
        end else begin
            if (b == CH_NUL) begin
                err = ERR_NO_TYPE;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                // digits go to the active number field
                if (spec_st.number_target == TGT_CLOSED) begin
                    err = ERR_EXTRA_NUMBER;
                end else if (spec_st.number_target == TGT_PREC) begin
                    acc = spec_st.precision_acc * 10 + (b - CH_ZERO);
                    if (acc > MAX_PRECISION) begin
                        spec_st.precision_acc = 8'(MAX_PRECISION);
                        err = ERR_PREC_LARGE;
                    end else begin
                        spec_st.precision_acc = 8'(acc);
                        ends = 1'b0;
                    end
                end else begin
                    acc = spec_st.width_acc * 10 + (b - CH_ZERO);
                    if (acc > MAX_WIDTH) begin
                        spec_st.width_acc = 9'(MAX_WIDTH);
                        err = ERR_WIDTH_LARGE;
                    end else begin
                        spec_st.width_acc = 9'(acc);
                        ends = 1'b0;
                    end
                end
            end else begin
                // any non-digit closes a number field holding a nonzero value
                if (spec_st.number_target == TGT_PREC && spec_st.precision_acc != 0)
                    spec_st.number_target = TGT_CLOSED;
                else if (spec_st.number_target == TGT_WIDTH && spec_st.width_acc != 0)
                    spec_st.number_target = TGT_CLOSED;

                case (b)
                    CH_LD, CH_LI, CH_LO, CH_LU, CH_LX, CH_UX: begin
                        sgn = (b == CH_LD || b == CH_LI);
                        if (spec_st.h_count == 0 && spec_st.l_count == 0)
                            slot = sgn ? SLOT_INT : SLOT_UINT;
                        else if (spec_st.h_count == 1)
                            slot = sgn ? SLOT_SHORT : SLOT_USHORT;
                        else if (spec_st.h_count == 2)
                            slot = sgn ? SLOT_CHAR : SLOT_UCHAR;
                        else if (spec_st.l_count == 1)
                            slot = sgn ? SLOT_LONG : SLOT_ULONG;
                        else if (spec_st.l_count == 2)
                            slot = sgn ? SLOT_LONG64 : SLOT_ULONG64;
                        else if (spec_st.modifier_kind != MOD_NONE)
                            err = ERR_MOD_UNSUPP;
                    end
                    CH_LE, CH_UE, CH_LF, CH_UF, CH_LG, CH_UG, CH_LA, CH_UA: begin
                        slot = (spec_st.big_l_count == 0) ? SLOT_FLOAT : SLOT_LONGDOUBLE;
                    end
                    CH_LC: begin
                        if (spec_st.modifier_kind != MOD_NONE) err = ERR_MOD_UNSUPP;
                        else slot = SLOT_UCHAR;
                    end
                    CH_LS: begin
                        if (spec_st.modifier_kind != MOD_NONE) err = ERR_MOD_UNSUPP;
                        else slot = SLOT_STRING;
                    end
                    CH_PCT: slot = SLOT_PERCENT;
                    CH_BSLASH: ends = 1'b0;
                    CH_UC, CH_US, CH_LN, CH_LM: err = ERR_TYPE_UNSUPP;
                    CH_LL: begin
                        if (spec_st.modifier_kind == MOD_NONE) begin
                            spec_st.modifier_kind = MOD_L;
                            spec_st.l_count       = spec_st.l_count + 2'd1;
                            ends                  = 1'b0;
                        end else if (spec_st.modifier_kind != MOD_L
                                     || spec_st.l_count >= 2'd2) begin
                            err = ERR_TOO_MANY_MODS;
                        end else begin
                            spec_st.l_count = spec_st.l_count + 2'd1;
                            ends            = 1'b0;
                        end
                    end
                    CH_LH: begin
                        if (spec_st.modifier_kind == MOD_NONE) begin
                            spec_st.modifier_kind = MOD_H;
                            spec_st.h_count       = spec_st.h_count + 2'd1;
                            ends                  = 1'b0;
                        end else if (spec_st.modifier_kind != MOD_H
                                     || spec_st.h_count >= 2'd2) begin
                            err = ERR_TOO_MANY_MODS;
                        end else begin
                            spec_st.h_count = spec_st.h_count + 2'd1;
                            ends            = 1'b0;
                        end
                    end
                    CH_UL: begin
                        spec_st.big_l_count = spec_st.big_l_count + 2'd1;
                        if (spec_st.modifier_kind != MOD_NONE) begin
                            err = ERR_TOO_MANY_MODS;
                        end else begin
                            spec_st.modifier_kind = MOD_BIGL;
                            ends                  = 1'b0;
                        end
                    end
                    CH_LJ, CH_LQ, CH_LT, CH_LZ, CH_UZ: err = ERR_MOD_UNSUPP;
                    CH_DOT: begin
                        if (spec_st.dot_seen) begin
                            err = ERR_DOTS;
                        end else begin
                            spec_st.number_target = TGT_PREC;
                            spec_st.dot_seen      = 1'b1;
                            ends                  = 1'b0;
                        end
                    end
                    CH_DOLLAR: err = ERR_DOLLAR;
                    CH_STAR: err = spec_st.dot_seen ? ERR_STAR_PREC : ERR_STAR_WIDTH;
                    CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH: begin
                        if (spec_st.dot_seen) err = ERR_FLAG_ORDER;
                        else ends = 1'b0;
                    end
                    default: err = ERR_BAD_CHAR;
                endcase
            end

            // a finished specifier reports its fields and drops back to idle
            emits = ends;
            if (ends) begin
                res.slot_type       = slot;
                res.error_code      = err;
                res.field_width     = spec_st.width_acc;
                res.field_precision = spec_st.precision_acc;
                res.bad_char        = b;
                spec_st             = STATE_CLEAR;
            end
        end
    endtask

    // watch both channels: compare results first, then predict from new bytes
    always @(posedge i_clk) begin : watch
        bit      emits;
        t_result predicted;
        t_result seen;
        if (!i_rst_n) begin
            spec_st = STATE_CLEAR;
            spec_results_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                seen.slot_type       = i_slot_type;
                seen.error_code      = i_error_code;
                seen.field_width     = i_field_width;
                seen.field_precision = i_field_precision;
                seen.bad_char        = i_bad_char;
                if (spec_results_q.size() == 0) begin
                    if (mismatch_total < 10)
                        $display("%0t: result item with none expected: type %0d err %0d",
                                 $realtime, seen.slot_type, seen.error_code);
                    mismatch_total++;
                end else begin
                    predicted = spec_results_q.pop_front();
                    if (seen.slot_type != predicted.slot_type
                        || seen.error_code != predicted.error_code
                        || seen.field_width != predicted.field_width
                        || seen.field_precision != predicted.field_precision
                        || seen.bad_char != predicted.bad_char) begin
                        if (mismatch_total < 10) begin
                            $write("%0t: spec result mismatch: expected type %0d err %0d ",
                                   $realtime, predicted.slot_type, predicted.error_code);
                            $write("width %0d prec %0d char %02h, ", predicted.field_width,
                                   predicted.field_precision, predicted.bad_char);
                            $display("got type %0d err %0d width %0d prec %0d char %02h",
                                     seen.slot_type, seen.error_code, seen.field_width,
                                     seen.field_precision, seen.bad_char);
                        end
                        mismatch_total++;
                    end
                end
            end
            if (i_ch_valid && i_ch_ready) begin
                parse_format_byte(i_ch, emits, predicted);
                if (emits) spec_results_q.push_back(predicted);
            end
        end
        o_mismatches    <= mismatch_total;
        o_specs_pending <= spec_results_q.size();
    end

endmodule

/* tb/printf_conversion_spec_parser_tb.sv */
module printf_conversion_spec_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcsp_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SPEC_BYTES  = 1900;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_ch    = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_slot_type;
    logic [3:0] o_error_code;
    logic [8:0] o_field_width;
    logic [7:0] o_field_precision;
    logic [7:0] o_bad_char;

    int mismatches;
    int specs_pending;
    int elapsed_cycles = 0;
    int burst_left     = 0;
    bit steady_sender  = 1'b0;
    int ready_run      = 0;
    int sink_mode      = 0;

    logic [7:0] fmt_q[$];

    // idle bytes, closed field then digit, width and precision overflow,
    // backslash with L on d, modifier on c, flag after dot, NUL, literal percent
    logic [7:0] directed_bytes[30] = '{
        8'hFF, CH_NUL,
        CH_PCT, CH_ZERO + 8'd5, CH_MINUS, CH_ZERO + 8'd3,
        CH_PCT, CH_ZERO + 8'd2, CH_ZERO + 8'd5, CH_ZERO + 8'd7,
        CH_PCT, CH_DOT, CH_ZERO + 8'd1, CH_NINE, CH_ZERO + 8'd3,
        CH_PCT, CH_BSLASH, CH_UL, CH_LD,
        CH_PCT, CH_LL, CH_LC,
        CH_PCT, CH_DOT, CH_ZERO + 8'd2, CH_MINUS,
        CH_PCT, CH_NUL,
        CH_PCT, CH_PCT
    };

    logic [7:0] conv_chars[17] = '{
        CH_LD, CH_LI, CH_LO, CH_LU, CH_LX, CH_UX, CH_LE, CH_UE, CH_LF,
        CH_UF, CH_LG, CH_UG, CH_LA, CH_UA, CH_LC, CH_LS, CH_PCT
    };
    logic [7:0] reject_chars[8] = '{
        CH_UC, CH_US, CH_LN, CH_LM, CH_DOLLAR, CH_STAR, CH_DOT, CH_NUL
    };
    logic [7:0] flag_chars[4]   = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH};
    logic [7:0] odd_mod_chars[5] = '{CH_LJ, CH_LQ, CH_LT, CH_LZ, CH_UZ};

    printf_conversion_spec_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_ch              (i_ch),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_slot_type       (o_slot_type),
        .o_error_code      (o_error_code),
        .o_field_width     (o_field_width),
        .o_field_precision (o_field_precision),
        .o_bad_char        (o_bad_char)
    );

    printf_conversion_spec_parser_checker u_spec_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ch_valid        (i_valid),
        .i_ch_ready        (o_ready),
        .i_ch              (i_ch),
        .i_res_valid       (o_valid),
        .i_res_ready       (i_ready),
        .i_slot_type       (o_slot_type),
        .i_error_code      (o_error_code),
        .i_field_width     (o_field_width),
        .i_field_precision (o_field_precision),
        .i_bad_char        (o_bad_char),
        .o_mismatches      (mismatches),
        .o_specs_pending   (specs_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        elapsed_cycles = elapsed_cycles + 1;
        if (elapsed_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: open stretches, random stalls, or alternating stall runs
    always @(posedge i_clk) begin
        if (ready_run > 0) ready_run = ready_run - 1;
        if (ready_run == 0) begin
            if ($urandom_range(0, 7) == 0) sink_mode = $urandom_range(0, 2);
            if (sink_mode == 0) begin
                i_ready <= 1'b1;
                ready_run = $urandom_range(20, 60);
            end else if (sink_mode == 1) begin
                i_ready <= ($urandom_range(0, 2) != 0);
                ready_run = 1;
            end else if (i_ready) begin
                i_ready <= 1'b0;
                ready_run = $urandom_range(1, 12);
            end else begin
                i_ready <= 1'b1;
                ready_run = $urandom_range(1, 6);
            end
        end
    end

    // offer one byte, with a random gap at the start of each burst
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_valid <= 1'b1;
        i_ch    <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // hold off the sender until every pending spec result has come out
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (specs_pending != 0) @(posedge i_clk);
    endtask

    task automatic add_number(input int unsigned value);
        logic [7:0] digits[$];
        do begin
            digits.push_front(CH_ZERO + 8'(value % 10));
            value = value / 10;
        end while (value != 0);
        foreach (digits[k]) fmt_q.push_back(digits[k]);
    endtask

    // one specifier: flags, width, precision, length modifier, conversion
    task automatic build_spec();
        int pick;
        fmt_q.delete();
        fmt_q.push_back(CH_PCT);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) fmt_q.push_back(flag_chars[$urandom_range(0, 3)]);

        pick = $urandom_range(0, 9);
        if (pick >= 4) begin
            if ($urandom_range(0, 4) == 0) fmt_q.push_back(CH_ZERO);
            if (pick <= 6) add_number($urandom_range(0, 99));
            else if (pick == 7) add_number($urandom_range(100, 256));
            else add_number($urandom_range(250, 300));
        end
        // stray byte that may close the width early
        if ($urandom_range(0, 11) == 0)
            fmt_q.push_back($urandom_range(0, 1) ? CH_BSLASH : flag_chars[$urandom_range(0, 3)]);

        pick = $urandom_range(0, 9);
        if (pick >= 4) begin
            fmt_q.push_back(CH_DOT);
            if (pick == 6 || pick == 7) add_number($urandom_range(0, 30));
            else if (pick == 8) add_number($urandom_range(150, 192));
            else if (pick == 9) add_number($urandom_range(185, 260));
            if ($urandom_range(0, 11) == 0) fmt_q.push_back(flag_chars[$urandom_range(0, 3)]);
        end

        pick = $urandom_range(0, 15);
        if (pick == 6) begin
            fmt_q.push_back(CH_LH);
        end else if (pick == 7) begin
            fmt_q.push_back(CH_LH);
            fmt_q.push_back(CH_LH);
        end else if (pick == 8) begin
            fmt_q.push_back(CH_LL);
        end else if (pick == 9) begin
            fmt_q.push_back(CH_LL);
            fmt_q.push_back(CH_LL);
        end else if (pick == 10) begin
            fmt_q.push_back(CH_UL);
        end else if (pick == 11) begin
            repeat (3) fmt_q.push_back($urandom_range(0, 1) ? CH_LH : CH_LL);
        end else if (pick == 12) begin
            fmt_q.push_back(CH_LL);
            fmt_q.push_back(CH_LH);
        end else if (pick == 13) begin
            fmt_q.push_back(CH_UL);
            fmt_q.push_back($urandom_range(0, 1) ? CH_UL : CH_LL);
        end else if (pick == 14) begin
            fmt_q.push_back(CH_LH);
            fmt_q.push_back(CH_UL);
        end else if (pick == 15) begin
            fmt_q.push_back(odd_mod_chars[$urandom_range(0, 4)]);
        end

        pick = $urandom_range(0, 19);
        if (pick < 14) fmt_q.push_back(conv_chars[$urandom_range(0, 16)]);
        else if (pick < 17) fmt_q.push_back(reject_chars[$urandom_range(0, 7)]);
        else if (pick < 18) fmt_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        else fmt_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int spec_items;
        int filler;
        spec_items = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        wait_results_drained();

        // mostly well-formed specifiers with random content, some raw noise
        while (spec_items < SPEC_BYTES) begin
            if ($urandom_range(0, 99) == 0) steady_sender = !steady_sender;
            if ($urandom_range(0, 7) == 0) begin
                fmt_q.delete();
                repeat ($urandom_range(1, 6)) fmt_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                filler = $urandom_range(0, 3);
                repeat (filler) send_byte(8'($urandom_range(32, 126)));
                spec_items += filler;
                build_spec();
            end
            foreach (fmt_q[k]) send_byte(fmt_q[k]);
            spec_items += fmt_q.size();
            if ($urandom_range(0, 59) == 0) wait_results_drained();
        end

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && specs_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/pcsp_pkg.sv
hdl/pcsp_step.sv
hdl/printf_conversion_spec_parser.sv
tb/printf_conversion_spec_parser_checker.sv
tb/printf_conversion_spec_parser_tb.sv
